>>> rtl/pcrd_pkg.sv
package pcrd_pkg;

   // defaults for the top level parameters
   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int FRACTION_BITS_DEF = 14;

   // fixed field widths
   localparam int PIX_W      = 12;
   localparam int VEC_W      = 48;
   localparam int COMP_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int SCALE_FRAC = 8;
   localparam int SIZE_W     = 13;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // largest direction component magnitude is normalized into [2^(NORM_TOP-1), 2^NORM_TOP]
   localparam int NORM_TOP = 30;

   // output saturation limits
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   // register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd256;
   localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW,
      CSR_RIGHT,
      CSR_UP,
      CSR_HSCALE,
      CSR_VSCALE,
      CSR_WIDTH,
      CSR_HEIGHT
   } csr_index_type;

   // camera configuration
   typedef struct packed {
      logic [VEC_W-1:0]   view_vector;
      logic [VEC_W-1:0]   right_vector;
      logic [VEC_W-1:0]   up_vector;
      logic [SCALE_W-1:0] horizontal_scale;
      logic [SCALE_W-1:0] vertical_scale;
      logic [SIZE_W-1:0]  frame_width;
      logic [SIZE_W-1:0]  frame_height;
   } cfg_type;

   // one ray direction
   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } ray_type;

endpackage

>>> rtl/pinhole_camera_ray_direction_core.sv
// Pinhole camera primary ray direction. Each item is one pixel (row, column); the block
// returns the unit ray direction through it in Q2.14 (x, y, z). One item is accepted every
// clock while the result side keeps up; the pipeline is built from two bit-per-stage dividers
// and a bit-per-stage square root. A two-entry output buffer keeps req_ready registered; when
// both entries are full the whole pipeline holds. Registers are taken from the csr port at once
// and must only change while no item is in flight; frame sizes are clamped to 1..MAX_DIMENSION.
module pinhole_camera_ray_direction_core
   import pcrd_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_row,
   input  logic [PIX_W-1:0]      req_pixel_col,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [OUT_W-1:0] rsp_ray_x,
   output logic signed [OUT_W-1:0] rsp_ray_y,
   output logic signed [OUT_W-1:0] rsp_ray_z,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{view_vector: '0, right_vector: '0, up_vector: '0,
                     horizontal_scale: SCALE_RESET, vertical_scale: SCALE_RESET,
                     frame_width: WIDTH_RESET, frame_height: HEIGHT_RESET};
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW:   cfg_ff.view_vector      <= csr_wdata[VEC_W-1:0];
            CSR_RIGHT:  cfg_ff.right_vector     <= csr_wdata[VEC_W-1:0];
            CSR_UP:     cfg_ff.up_vector        <= csr_wdata[VEC_W-1:0];
            CSR_HSCALE: cfg_ff.horizontal_scale <= csr_wdata[SCALE_W-1:0];
            CSR_VSCALE: cfg_ff.vertical_scale   <= csr_wdata[SCALE_W-1:0];
            CSR_WIDTH:  cfg_ff.frame_width      <= csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT: cfg_ff.frame_height     <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline
   logic    en;
   logic    dp_valid;
   ray_type dp_ray;

   pcrd_datapath #(
      .MAX_DIMENSION(MAX_DIMENSION),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .pixel_row(req_pixel_row),
      .pixel_col(req_pixel_col),
      .cfg      (cfg_ff),
      .out_valid(dp_valid),
      .out_ray  (dp_ray)
   );

   // output register plus skid entry
   logic    out_valid_ff, skid_valid_ff;
   ray_type out_ff, skid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (dp_valid) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (dp_valid) begin
         if (!out_valid_ff || rsp_ready) begin
            out_ff <= dp_ray;
         end else begin
            skid_ff <= dp_ray;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_ray_x = out_ff.x;
   assign rsp_ray_y = out_ff.y;
   assign rsp_ray_z = out_ff.z;

   // skid entry fills only behind a held result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid entry filled while output was free");

   // a buffered item always sits behind a shown one
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a held pipeline keeps its last stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dp_valid) && $stable(dp_ray))
      else $error("pipeline moved while held");

endmodule

>>> rtl/pcrd_datapath.sv
module pcrd_datapath
   import pcrd_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] pixel_row,
   input  logic [PIX_W-1:0] pixel_col,
   input  cfg_type          cfg,
   output logic             out_valid,
   output ray_type          out_ray
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int AW    = (DIM_W > PIX_W + 1) ? DIM_W : PIX_W + 1;
   localparam int QXW   = AW + FRACTION_BITS;
   localparam int CXW   = QXW + 1;
   localparam int PXW   = CXW + SCALE_W;
   localparam int SXW   = PXW - SCALE_FRAC;
   localparam int PVW   = SXW + COMP_W;
   localparam int DW    = PVW + 2;
   localparam int PW    = $clog2(DW);
   localparam int NW    = NORM_TOP + 2;
   localparam int SUMW  = 2 * NORM_TOP + 2;
   localparam int RW    = NORM_TOP + 1;
   localparam int REMW  = RW + 2;
   localparam int MAGW  = NORM_TOP + 1;
   localparam int QB    = FRACTION_BITS + 2;
   localparam int CW    = RW + QB;
   localparam int NST   = QXW + RW + QB + 12;

   // helpers
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > MAX_DIMENSION) begin
         return DIM_W'(MAX_DIMENSION);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v, input int c);
      return $signed(v[COMP_W*c +: COMP_W]);
   endfunction

   function automatic logic [DIM_W+QXW-1:0] cdiv_step(input logic [DIM_W-1:0] r,
                                                      input logic [QXW-1:0]   dq,
                                                      input logic [DIM_W-1:0] dv);
      logic [DIM_W:0]   r2;
      logic [DIM_W-1:0] rn;
      logic             b;
      r2 = {r, dq[QXW-1]};
      if (r2 >= {1'b0, dv}) begin
         rn = DIM_W'(r2 - {1'b0, dv});
         b  = 1'b1;
      end else begin
         rn = r2[DIM_W-1:0];
         b  = 1'b0;
      end
      return {rn, dq[QXW-2:0], b};
   endfunction

   function automatic logic [REMW+RW-1:0] sqrt_step(input logic [REMW-1:0] rem,
                                                    input logic [RW-1:0]   root,
                                                    input logic [1:0]      pair);
      logic [REMW+1:0] ext;
      logic [REMW+1:0] trial;
      logic [REMW-1:0] rn;
      logic [RW-1:0]   qn;
      ext   = {rem, pair};
      trial = (REMW+2)'({root, 2'b01});
      if (ext >= trial) begin
         rn = REMW'(ext - trial);
         qn = {root[RW-2:0], 1'b1};
      end else begin
         rn = REMW'(ext);
         qn = {root[RW-2:0], 1'b0};
      end
      return {rn, qn};
   endfunction

   function automatic logic signed [OUT_W-1:0] saturate(input logic [QB-1:0] q, input logic neg);
      logic signed [QB:0] s;
      s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (int'(s) > OUT_MAX) begin
         return OUT_W'(OUT_MAX);
      end else if (int'(s) < OUT_MIN) begin
         return OUT_W'(OUT_MIN);
      end else begin
         return OUT_W'(s);
      end
   endfunction

   // valid bits, one per stage
   logic [NST-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[NST-1];

   // clamped frame size
   logic [DIM_W-1:0] frame_w, frame_h;

   assign frame_w = clamp_dim(cfg.frame_width);
   assign frame_h = clamp_dim(cfg.frame_height);

   // offset of pixel from frame center, doubled
   logic signed [AW:0] col_diff, row_diff;
   logic [AW-1:0]      col_mag, row_mag;

   assign col_diff = $signed({1'b0, AW'({pixel_col, 1'b0})}) - $signed({1'b0, AW'(frame_w)});
   assign row_diff = $signed({1'b0, AW'({pixel_row, 1'b0})}) - $signed({1'b0, AW'(frame_h)});
   assign col_mag  = col_diff[AW] ? AW'(-col_diff) : AW'(col_diff);
   assign row_mag  = row_diff[AW] ? AW'(-row_diff) : AW'(row_diff);

   // centered coordinate division, one quotient bit per stage
   logic [QXW-1:0]   xq_ff [0:QXW];
   logic [QXW-1:0]   yq_ff [0:QXW];
   logic [DIM_W-1:0] xr_ff [0:QXW];
   logic [DIM_W-1:0] yr_ff [0:QXW];
   logic             xn_ff [0:QXW];
   logic             yn_ff [0:QXW];

   always_ff @(posedge clock) begin
      if (en) begin
         xq_ff[0] <= {col_mag, {FRACTION_BITS{1'b0}}};
         yq_ff[0] <= {row_mag, {FRACTION_BITS{1'b0}}};
         xr_ff[0] <= '0;
         yr_ff[0] <= '0;
         xn_ff[0] <= col_diff[AW];
         yn_ff[0] <= row_diff[AW];
      end
   end

   for (genvar k = 0; k < QXW; k++) begin : g_cdiv
      always_ff @(posedge clock) begin
         if (en) begin
            {xr_ff[k+1], xq_ff[k+1]} <= cdiv_step(xr_ff[k], xq_ff[k], frame_w);
            {yr_ff[k+1], yq_ff[k+1]} <= cdiv_step(yr_ff[k], yq_ff[k], frame_h);
            xn_ff[k+1] <= xn_ff[k];
            yn_ff[k+1] <= yn_ff[k];
         end
      end
   end

   // apply sign, then scale by field of view
   logic signed [CXW-1:0] cx_ff, cy_ff;
   logic signed [PXW-1:0] px_ff, py_ff;
   logic signed [SXW-1:0] sx, sy;

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= xn_ff[QXW] ? -$signed({1'b0, xq_ff[QXW]}) : $signed({1'b0, xq_ff[QXW]});
         cy_ff <= yn_ff[QXW] ? -$signed({1'b0, yq_ff[QXW]}) : $signed({1'b0, yq_ff[QXW]});
         px_ff <= cx_ff * $signed({1'b0, cfg.horizontal_scale});
         py_ff <= cy_ff * $signed({1'b0, cfg.vertical_scale});
      end
   end

   // floor shift of the Q8.8 scale
   assign sx = px_ff[PXW-1:SCALE_FRAC];
   assign sy = py_ff[PXW-1:SCALE_FRAC];

   // basis products, direction sum, magnitude
   logic signed [PVW-1:0]  pr_ff [0:2];
   logic signed [PVW-1:0]  pu_ff [0:2];
   logic signed [DW-1:0]   d_ff  [0:2];
   logic signed [DW-1:0]   da_ff [0:2];
   logic [DW-1:0]          ma_ff [0:2];
   logic signed [DW-1:0]   dl_ff [0:2];
   logic signed [NW-1:0]   dn_ff [0:2];
   logic signed [2*NW-1:0] sq_full [0:2];
   logic [SUMW-1:0]        sq_ff [0:2];
   logic [MAGW-1:0]        mg_ff [0:2];
   logic                   sg_ff [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic signed [COMP_W-1:0] vc;
      logic signed [DW-1:0]     vterm;

      assign vc         = comp(cfg.view_vector, c);
      assign vterm      = {{(DW-COMP_W-FRACTION_BITS){vc[COMP_W-1]}}, vc,
                           {FRACTION_BITS{1'b0}}};
      assign sq_full[c] = dn_ff[c] * dn_ff[c];

      always_ff @(posedge clock) begin
         if (en) begin
            pr_ff[c] <= sx * comp(cfg.right_vector, c);
            pu_ff[c] <= sy * comp(cfg.up_vector, c);
            d_ff[c]  <= vterm + pr_ff[c] + pu_ff[c];
            da_ff[c] <= d_ff[c];
            ma_ff[c] <= d_ff[c][DW-1] ? DW'(-d_ff[c]) : DW'(d_ff[c]);
            dl_ff[c] <= da_ff[c];
            sq_ff[c] <= sq_full[c][SUMW-1:0];
            mg_ff[c] <= dn_ff[c][NW-1] ? MAGW'(-dn_ff[c]) : MAGW'(dn_ff[c]);
            sg_ff[c] <= dn_ff[c][NW-1];
         end
      end
   end

   // leading one of the largest component sets the normalizing shift
   logic [DW-1:0] norm_or;
   logic [PW-1:0] lead_pos;
   logic [PW-1:0] kl_ff;
   logic          rl_ff;
   logic          zl_ff, zn_ff, zq_ff;

   always_comb begin
      norm_or  = ma_ff[0] | ma_ff[1] | ma_ff[2];
      lead_pos = '0;
      for (int b = 0; b < DW; b++) begin
         if (norm_or[b]) begin
            lead_pos = PW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zl_ff <= (norm_or == '0);
         rl_ff <= (lead_pos >= PW'(NORM_TOP));
         kl_ff <= (lead_pos >= PW'(NORM_TOP)) ? lead_pos - PW'(NORM_TOP - 1)
                                               : PW'(NORM_TOP - 1) - lead_pos;
         zn_ff <= zl_ff;
         zq_ff <= zn_ff;
      end
   end

   // apply the shift: floor going right, exact going left
   for (genvar c = 0; c < 3; c++) begin : g_norm
      always_ff @(posedge clock) begin
         if (en) begin
            dn_ff[c] <= rl_ff ? NW'(dl_ff[c] >>> kl_ff) : NW'(dl_ff[c] <<< kl_ff);
         end
      end
   end

   // square root of the sum of squares, one root bit per stage
   logic [REMW-1:0] rr_ff [0:RW];
   logic [RW-1:0]   rq_ff [0:RW];
   logic [SUMW-1:0] rv_ff [0:RW];
   logic [MAGW-1:0] rm_ff [0:RW][0:2];
   logic            rs_ff [0:RW][0:2];
   logic            rz_ff [0:RW];

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff[0] <= '0;
         rq_ff[0] <= '0;
         rv_ff[0] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         rz_ff[0] <= zq_ff;
         for (int c = 0; c < 3; c++) begin
            rm_ff[0][c] <= mg_ff[c];
            rs_ff[0][c] <= sg_ff[c];
         end
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            {rr_ff[k+1], rq_ff[k+1]} <= sqrt_step(rr_ff[k], rq_ff[k], rv_ff[k][SUMW-1:SUMW-2]);
            rv_ff[k+1] <= {rv_ff[k][SUMW-3:0], 2'b00};
            rz_ff[k+1] <= rz_ff[k];
            for (int c = 0; c < 3; c++) begin
               rm_ff[k+1][c] <= rm_ff[k][c];
               rs_ff[k+1][c] <= rs_ff[k][c];
            end
         end
      end
   end

   // component divided by length, one quotient bit per stage
   logic [CW-1:0] vr_ff [0:QB][0:2];
   logic [QB-1:0] vq_ff [0:QB][0:2];
   logic          vs_ff [0:QB][0:2];
   logic [RW-1:0] vl_ff [0:QB];
   logic          vz_ff [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         vl_ff[0] <= rq_ff[RW];
         vz_ff[0] <= rz_ff[RW];
         for (int c = 0; c < 3; c++) begin
            vr_ff[0][c] <= CW'({rm_ff[RW][c], {FRACTION_BITS{1'b0}}});
            vq_ff[0][c] <= '0;
            vs_ff[0][c] <= rs_ff[RW][c];
         end
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_ndiv
      localparam int BI = QB - 1 - k;
      logic [CW-1:0] vt;

      assign vt = CW'(vl_ff[k]) << BI;

      always_ff @(posedge clock) begin
         if (en) begin
            vl_ff[k+1] <= vl_ff[k];
            vz_ff[k+1] <= vz_ff[k];
            for (int c = 0; c < 3; c++) begin
               vs_ff[k+1][c] <= vs_ff[k][c];
               if (vr_ff[k][c] >= vt) begin
                  vr_ff[k+1][c] <= vr_ff[k][c] - vt;
                  vq_ff[k+1][c] <= vq_ff[k][c] | (QB'(1) << BI);
               end else begin
                  vr_ff[k+1][c] <= vr_ff[k][c];
                  vq_ff[k+1][c] <= vq_ff[k][c];
               end
            end
         end
      end
   end

   // sign, saturation, zero direction
   ray_type ray_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (vz_ff[QB]) begin
            ray_ff <= '0;
         end else begin
            ray_ff.x <= saturate(vq_ff[QB][0], vs_ff[QB][0]);
            ray_ff.y <= saturate(vq_ff[QB][1], vs_ff[QB][1]);
            ray_ff.z <= saturate(vq_ff[QB][2], vs_ff[QB][2]);
         end
      end
   end

   assign out_ray = ray_ff;

endmodule

>>> bench/tb_pinhole_camera_ray_direction_core.sv
module tb_pinhole_camera_ray_direction_core;
   import pcrd_pkg::*;

   localparam int FB      = FRACTION_BITS_DEF;
   localparam int MAX_DIM = MAX_DIMENSION_DEF;
   localparam int LATENCY = 100;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_pixel_row;
   logic [PIX_W-1:0]        req_pixel_col;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [OUT_W-1:0] rsp_ray_x;
   logic signed [OUT_W-1:0] rsp_ray_y;
   logic signed [OUT_W-1:0] rsp_ray_z;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // camera setting as the bench believes it to be
   logic [VEC_W-1:0]   cam_view;
   logic [VEC_W-1:0]   cam_right;
   logic [VEC_W-1:0]   cam_up;
   logic [SCALE_W-1:0] cam_hscale;
   logic [SCALE_W-1:0] cam_vscale;
   logic [SIZE_W-1:0]  cam_width;
   logic [SIZE_W-1:0]  cam_height;

   ray_type expected_rays[$];
   int      mismatch_count;
   int      stall_hold;
   int      burst_left;

   pinhole_camera_ray_direction_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_row(req_pixel_row), .req_pixel_col(req_pixel_col),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ray_x(rsp_ray_x), .rsp_ray_y(rsp_ray_y), .rsp_ray_z(rsp_ray_z),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // run limit
   initial begin
      #(12 * 2000000);
      $display("Regression FAIL");
      $finish;
   end

   // floor division by a power of two
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint vec_comp(logic [VEC_W-1:0] packed_vec, int idx);
      logic signed [COMP_W-1:0] raw;
      raw = packed_vec[idx*COMP_W +: COMP_W];
      return longint'(raw);
   endfunction

   function automatic longint clamp_size(logic [SIZE_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return longint'(v);
   endfunction

   function automatic longint long_abs(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // unit ray direction through one pixel
   function automatic ray_type ray_through_pixel(logic [PIX_W-1:0] row,
                                                 logic [PIX_W-1:0] col);
      longint w, h, nx, ny, sx, sy, m, r;
      longint d[3];
      longint unsigned sum, len, a;
      int k;
      ray_type ray;
      w = clamp_size(cam_width);
      h = clamp_size(cam_height);
      nx = ((2 * longint'(col) - w) * (longint'(1) << FB)) / w;
      ny = ((2 * longint'(row) - h) * (longint'(1) << FB)) / h;
      sx = floor_shift(nx * longint'(cam_hscale), SCALE_FRAC);
      sy = floor_shift(ny * longint'(cam_vscale), SCALE_FRAC);
      m = 0;
      for (int c = 0; c < 3; c++) begin
         d[c] = vec_comp(cam_view, c) * (longint'(1) << FB)
              + sx * vec_comp(cam_right, c) + sy * vec_comp(cam_up, c);
         if (long_abs(d[c]) > m) m = long_abs(d[c]);
      end
      ray = '0;
      if (m == 0) return ray;
      k = 0;
      if (m >= (longint'(1) << NORM_TOP)) begin
         while ((m >>> k) >= (longint'(1) << NORM_TOP)) k++;
         for (int c = 0; c < 3; c++) d[c] = floor_shift(d[c], k);
      end else begin
         while ((m <<< k) < (longint'(1) << (NORM_TOP - 1))) k++;
         for (int c = 0; c < 3; c++) d[c] = d[c] * (longint'(1) << k);
      end
      sum = 0;
      for (int c = 0; c < 3; c++) begin
         a = longint'(long_abs(d[c]));
         sum += a * a;
      end
      len = int_sqrt(sum);
      for (int c = 0; c < 3; c++) begin
         r = 0;
         if (len != 0) r = (d[c] * (longint'(1) << FB)) / longint'(len);
         if (r > OUT_MAX) r = OUT_MAX;
         if (r < OUT_MIN) r = OUT_MIN;
         if (c == 0) ray.x = r[OUT_W-1:0];
         else if (c == 1) ray.y = r[OUT_W-1:0];
         else ray.z = r[OUT_W-1:0];
      end
      return ray;
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      ray_type exp_ray;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rays.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected ray %0d %0d %0d", rsp_ray_x, rsp_ray_y, rsp_ray_z);
         end else begin
            exp_ray = expected_rays.pop_front();
            if (exp_ray.x !== rsp_ray_x || exp_ray.y !== rsp_ray_y ||
                exp_ray.z !== rsp_ray_z) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ray mismatch exp %0d %0d %0d got %0d %0d %0d",
                           exp_ray.x, exp_ray.y, exp_ray.z,
                           rsp_ray_x, rsp_ray_y, rsp_ray_z);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // send one pixel item, with bursty gaps
   task automatic send_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_pixel_row = row;
      req_pixel_col = col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rays.push_back(ray_through_pixel(row, col));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      while (expected_rays.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_VIEW:   cam_view = value;
         CSR_RIGHT:  cam_right = value;
         CSR_UP:     cam_up = value;
         CSR_HSCALE: cam_hscale = value[SCALE_W-1:0];
         CSR_VSCALE: cam_vscale = value[SCALE_W-1:0];
         CSR_WIDTH:  cam_width = value[SIZE_W-1:0];
         CSR_HEIGHT: cam_height = value[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
      return {z[15:0], y[15:0], x[15:0]};
   endfunction

   task automatic set_camera(logic [VEC_W-1:0] v, logic [VEC_W-1:0] r,
                             logic [VEC_W-1:0] u, int hs, int vs, int w, int h);
      write_reg(CSR_VIEW, v);
      write_reg(CSR_RIGHT, r);
      write_reg(CSR_UP, u);
      write_reg(CSR_HSCALE, CSR_DATA_W'(hs));
      write_reg(CSR_VSCALE, CSR_DATA_W'(vs));
      write_reg(CSR_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic random_camera();
      set_camera(VEC_W'({$urandom, $urandom}), VEC_W'({$urandom, $urandom}),
                 VEC_W'({$urandom, $urandom}),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
   endtask

   // reset defaults: all vectors zero gives zero directions
   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(479, 639);
      wait_idle();
   endtask

   // frame corners, center, out of frame, size clamping and a write to an unused register index
   task automatic test_directed();
      set_camera(pack_vec(0, 0, 16384), pack_vec(16384, 0, 0), pack_vec(0, -16384, 0),
                 256, 192, 640, 480);
      send_pixel(0, 0);
      send_pixel(479, 639);
      send_pixel(240, 320);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      wait_idle();
      set_camera(pack_vec(-32768, -32768, -32768), pack_vec(32767, 32767, 32767),
                 pack_vec(-32768, 32767, -32768), 65535, 65535, 0, 8191);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(1, 0);
      wait_idle();
      set_camera(pack_vec(1, 0, 0), pack_vec(0, 0, 0), pack_vec(0, 0, 0), 0, 0, 1, 4096);
      send_pixel(0, 0);
      send_pixel(2048, 1);
      wait_idle();
      // one component cancels to zero at the center column
      set_camera(pack_vec(0, 0, 0), pack_vec(16384, 0, 0), pack_vec(0, 0, 0),
                 256, 256, 4097, 2);
      send_pixel(1, 2048);
      send_pixel(0, 0);
      send_pixel(2730, 1365);
      wait_idle();
      write_reg(csr_index_type'(7), CSR_DATA_W'({$urandom, $urandom}));
      send_pixel(3, 5);
      wait_idle();
   endtask

   // random cameras with mostly in-frame pixels
   task automatic test_random(int phases, int per_phase);
      int w, h;
      for (int p = 0; p < phases; p++) begin
         random_camera();
         if ($urandom_range(0, 3) != 0) begin
            write_reg(CSR_WIDTH, CSR_DATA_W'($urandom_range(1, 64)));
            write_reg(CSR_HEIGHT, CSR_DATA_W'($urandom_range(1, 64)));
         end
         w = int'(clamp_size(cam_width));
         h = int'(clamp_size(cam_height));
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 4) == 0)
               send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
            else
               send_pixel(PIX_W'($urandom_range(0, (h > 4096 ? 4096 : h) - 1)),
                          PIX_W'($urandom_range(0, (w > 4096 ? 4096 : w) - 1)));
         end
         wait_idle();
      end
   endtask

   // receiver holds off long while items keep coming
   task automatic test_backpressure();
      random_camera();
      stall_hold = 300;
      for (int i = 0; i < 150; i++)
         send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
      wait_idle();
   endtask

   initial begin
      req_valid = 1'b0;
      req_pixel_row = '0;
      req_pixel_col = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      stall_hold = 0;
      burst_left = 0;
      cam_view = '0;
      cam_right = '0;
      cam_up = '0;
      cam_hscale = SCALE_RESET;
      cam_vscale = SCALE_RESET;
      cam_width = WIDTH_RESET;
      cam_height = HEIGHT_RESET;
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_directed();
      test_backpressure();
      test_random(20, 50);
      if (mismatch_count == 0 && expected_rays.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
